// ===== rtl/pls_pkg.sv =====
package pls_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CntW     = 7;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned DataW    = 32;

  typedef logic [KindW-1:0]          kind_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic [CntW-1:0]           cnt_t;
  typedef logic [StatusW-1:0]        status_t;
  typedef logic signed [DataW-1:0]   data_t;

  localparam kind_t KindClear  = 3'd0;
  localparam kind_t KindInsert = 3'd1;
  localparam kind_t KindUpdate = 3'd2;
  localparam kind_t KindDelete = 3'd3;
  localparam kind_t KindRead   = 3'd4;

  localparam status_t StatusOk   = 2'd0;
  localparam status_t StatusBad  = 2'd1;
  localparam status_t StatusFull = 2'd2;

  localparam cnt_t CapacityCnt = cnt_t'(Capacity);

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic  shift_up;
    logic  shift_down;
    logic  write;
    pos_t  pos;
    data_t value;
  } cell_cmd_t;

endpackage

// ===== rtl/pls_req_if.sv =====
interface pls_req_if;
  import pls_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  pos_t  position;
  data_t item_value;

  modport source (output valid, kind, position, item_value, input ready);
  modport sink (input valid, kind, position, item_value, output ready);
endinterface

// ===== rtl/pls_rsp_if.sv =====
interface pls_rsp_if;
  import pls_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  data_t   read_value;
  cnt_t    entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== rtl/positional_list_store.sv =====
// Ordered list of up to 64 signed 32-bit entries held in a chain of cells, one
// entry per cell. When a request (clear, insert, update, delete, read) is taken,
// all cells shift or write together, and the result (status, read
// value, entry count) lands in an output register the next cycle. A new request
// is taken every cycle while the response side keeps taking results, so one
// request per cycle is sustained; a stalled response holds off further requests.
// Bad positions and inserts into a full list leave the list unchanged.
module positional_list_store (
  input logic       clk_i,
  input logic       rst_ni,
  pls_req_if.sink   req_i,
  pls_rsp_if.source rsp_o
);
  import pls_pkg::*;

  cnt_t      count_q;
  cnt_t      count_d;
  logic      out_valid_q;
  status_t   status_q;
  status_t   status_d;
  data_t     rdata_q;
  data_t     rdata_d;
  cnt_t      out_cnt_q;
  logic      accept;
  logic      pos_lt;
  logic      pos_le;
  logic      is_full;
  logic      do_read;
  cell_cmd_t cmd;

  data_t entry [Capacity];
  data_t rd    [Capacity];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign pos_lt  = cnt_t'(req_i.position) < count_q;
  assign pos_le  = cnt_t'(req_i.position) <= count_q;
  assign is_full = count_q >= CapacityCnt;

  always_comb begin
    count_d        = count_q;
    status_d       = StatusOk;
    do_read        = 1'b0;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    cmd.write      = 1'b0;
    cmd.pos        = req_i.position;
    cmd.value      = req_i.item_value;
    case (req_i.kind)
      KindClear: begin
        count_d = '0;
      end
      KindInsert: begin
        if (!pos_le) begin
          status_d = StatusBad;
        end else if (is_full) begin
          status_d = StatusFull;
        end else begin
          cmd.shift_up = accept;
          count_d      = count_q + cnt_t'(1);
        end
      end
      KindUpdate: begin
        if (!pos_lt) begin
          status_d = StatusBad;
        end else begin
          cmd.write = accept;
        end
      end
      KindDelete: begin
        if (!pos_lt) begin
          status_d = StatusBad;
        end else begin
          cmd.shift_down = accept;
          count_d        = count_q - cnt_t'(1);
        end
      end
      KindRead: begin
        if (!pos_lt) begin
          status_d = StatusBad;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    data_t left;
    data_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    pls_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (pos_t'(i)),
      .cmd_i      (cmd),
      .left_i     (left),
      .right_i    (right),
      .entry_o    (entry[i]),
      .rd_o       (rd[i])
    );
  end

  always_comb begin
    rdata_d = '0;
    for (int i = 0; i < Capacity; i++) begin
      rdata_d = rdata_d | rd[i];
    end
    if (!do_read) begin
      rdata_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rdata_q   <= rdata_d;
      out_cnt_q <= count_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.read_value  = rdata_q;
  assign rsp_o.entry_count = out_cnt_q;

  // list never grows past capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CapacityCnt)
    else $error("count exceeds capacity");

  // a full status only comes from a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == StatusFull |-> out_cnt_q == CapacityCnt)
    else $error("full status with room left");

  // failed requests return zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StatusOk |-> rdata_q == '0)
    else $error("nonzero data on failed request");

  // clear empties the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.kind == KindClear |=> count_q == '0 && out_cnt_q == '0)
    else $error("clear left entries");

  // reported count tracks the stored count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_cnt_q == count_q)
    else $error("reported count out of step");

endmodule

// ===== rtl/pls_cell.sv =====
module pls_cell (
  input  logic              clk_i,
  input  pls_pkg::pos_t     cell_idx_i,
  input  pls_pkg::cell_cmd_t cmd_i,
  input  pls_pkg::data_t    left_i,
  input  pls_pkg::data_t    right_i,
  output pls_pkg::data_t    entry_o,
  output pls_pkg::data_t    rd_o
);
  import pls_pkg::*;

  data_t entry_q;
  data_t entry_d;

  logic above;
  logic at;

  assign above = cell_idx_i > cmd_i.pos;
  assign at    = cell_idx_i == cmd_i.pos;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_up && above) begin
      entry_d = left_i;
    end else if ((cmd_i.shift_up || cmd_i.write) && at) begin
      entry_d = cmd_i.value;
    end else if (cmd_i.shift_down && (above || at)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = at ? entry_q : '0;

endmodule

// ===== tb/tb_positional_list_store.sv =====
`timescale 1ns / 100ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int    CycleLimit  = 400000;
  localparam int    HoldCycles  = 240;
  localparam int    PhaseItems  = 320;
  localparam int    MaxPrinted  = 40;
  localparam kind_t KindSpareLo = 3'd5;
  localparam kind_t KindSpareHi = 3'd7;

  typedef struct {
    status_t status;
    data_t   read_value;
    cnt_t    entry_count;
  } list_result_t;

  class list_scoreboard;
    data_t        mirror_entries [Capacity];
    cnt_t         mirror_count;
    list_result_t pending_results[$];
    int           errors;
    int           checked;
    int           full_hits;
    int           bad_hits;

    function new();
      foreach (mirror_entries[i]) mirror_entries[i] = '0;
      mirror_count = '0;
      errors       = 0;
      checked      = 0;
      full_hits    = 0;
      bad_hits     = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // apply one accepted request to the mirror list and queue its result
    function void note_request(kind_t kind, pos_t pos, data_t value);
      list_result_t r;
      int           i;
      r.status      = StatusOk;
      r.read_value  = '0;
      case (kind)
        KindClear: begin
          mirror_count = '0;
        end
        KindInsert: begin
          if (pos > mirror_count) begin
            r.status = StatusBad;
          end else if (mirror_count >= CapacityCnt) begin
            r.status = StatusFull;
          end else begin
            for (i = int'(mirror_count); i > int'(pos); i--)
              mirror_entries[i] = mirror_entries[i-1];
            mirror_entries[pos] = value;
            mirror_count++;
          end
        end
        KindUpdate: begin
          if (pos >= mirror_count) r.status = StatusBad;
          else mirror_entries[pos] = value;
        end
        KindDelete: begin
          if (pos >= mirror_count) begin
            r.status = StatusBad;
          end else begin
            for (i = int'(pos); i + 1 < int'(mirror_count); i++)
              mirror_entries[i] = mirror_entries[i+1];
            mirror_count--;
          end
        end
        KindRead: begin
          if (pos >= mirror_count) r.status = StatusBad;
          else r.read_value = mirror_entries[pos];
        end
        default: begin
        end
      endcase
      if (r.status == StatusFull) full_hits++;
      if (r.status == StatusBad) bad_hits++;
      r.entry_count = mirror_count;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(status_t status, data_t read_value, cnt_t entry_count);
      list_result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d value %0d count %0d",
                         status, read_value, entry_count));
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (status !== exp.status)
        report($sformatf("status %0d, expected %0d", status, exp.status));
      if (read_value !== exp.read_value)
        report($sformatf("read value %0d, expected %0d", read_value, exp.read_value));
      if (entry_count !== exp.entry_count)
        report($sformatf("entry count %0d, expected %0d", entry_count, exp.entry_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pls_req_if req_if();
  pls_rsp_if rsp_if();

  positional_list_store u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  list_scoreboard sb = new();

  int cycle_cnt     = 0;
  int items_sent    = 0;
  int req_idle_pct  = 0;
  int rsp_stall_pct = 0;
  int hold_requests = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // transfers are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.read_value, rsp_if.entry_count);
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.kind, req_if.position, req_if.item_value);
    end
  end

  // response side, with an occasional long hold-off
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  task send_request(kind_t kind, pos_t pos, data_t value);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.kind       = kind;
    req_if.position   = pos;
    req_if.item_value = value;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task wait_results_drained();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function data_t pick_value();
    case ($urandom_range(9))
      0: return data_t'(32'h7fff_ffff);
      1: return data_t'(32'h8000_0000);
      2: return $urandom_range(1) ? data_t'(0) : data_t'(-1);
      default: return data_t'($urandom);
    endcase
  endfunction

  // position inside the range that the kind accepts, now and then anywhere
  function pos_t pick_pos(kind_t kind);
    int top;
    top = int'(sb.mirror_count) - ((kind == KindInsert) ? 0 : 1);
    if (top < 0 || $urandom_range(9) == 0) return pos_t'($urandom_range(127));
    return pos_t'($urandom_range(top));
  endfunction

  function kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 38) return KindInsert;
    if (r < 53) return KindUpdate;
    if (r < 73) return KindDelete;
    if (r < 97) return KindRead;
    return KindClear;
  endfunction

  task fill_to_capacity();
    while (sb.mirror_count < CapacityCnt)
      send_request(KindInsert, pick_pos(KindInsert), pick_value());
    send_request(KindInsert, pos_t'($urandom_range(Capacity)), pick_value());
    send_request(KindInsert, pos_t'(Capacity), pick_value());
    send_request(KindInsert, pos_t'($urandom_range(Capacity + 1, 127)), pick_value());
    send_request(KindRead, pos_t'(Capacity - 1), '0);
    send_request(KindRead, pos_t'(Capacity), '0);
    send_request(KindUpdate, pos_t'(Capacity - 1), pick_value());
  endtask

  task drain_list();
    while (sb.mirror_count != 0)
      send_request(KindDelete, pick_pos(KindDelete), pick_value());
    send_request(KindDelete, pos_t'($urandom_range(127)), pick_value());
  endtask

  task run_phase(int idle_pct, int stall_pct);
    int target;
    int pick;
    int n;
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_pct;
    target = items_sent + PhaseItems;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // load: clear then appends
        send_request(KindClear, pos_t'($urandom_range(127)), pick_value());
        n = $urandom_range(1, 16);
        repeat (n) send_request(KindInsert, pos_t'(sb.mirror_count), pick_value());
      end else if (pick < 11) begin
        fill_to_capacity();
      end else if (pick < 14) begin
        drain_list();
      end else if (pick < 19) begin
        // full display
        for (int i = 0; i < int'(sb.mirror_count); i++)
          send_request(KindRead, pos_t'(i), pick_value());
      end else if (pick < 26) begin
        repeat (4) send_request(kind_t'($urandom_range(7)), pos_t'($urandom_range(127)),
                                data_t'($urandom));
      end else if (pick < 27) begin
        wait_results_drained();
      end else begin
        repeat (8) begin
          kind_t k;
          k = pick_kind();
          send_request(k, pick_pos(k), pick_value());
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KindClear;
    req_if.position   = '0;
    req_if.item_value = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty list, signed extremes, each kind, bad positions
    send_request(KindRead,   pos_t'(0),   '0);
    send_request(KindUpdate, pos_t'(0),   data_t'(1));
    send_request(KindDelete, pos_t'(0),   '0);
    send_request(KindInsert, pos_t'(1),   data_t'(5));
    send_request(KindInsert, pos_t'(0),   data_t'(32'h7fff_ffff));
    send_request(KindInsert, pos_t'(0),   data_t'(32'h8000_0000));
    send_request(KindInsert, pos_t'(2),   data_t'(-1));
    send_request(KindInsert, pos_t'(1),   data_t'(0));
    send_request(KindRead,   pos_t'(0),   '0);
    send_request(KindRead,   pos_t'(1),   '0);
    send_request(KindRead,   pos_t'(2),   '0);
    send_request(KindRead,   pos_t'(3),   '0);
    send_request(KindUpdate, pos_t'(3),   data_t'(32'h5555_5555));
    send_request(KindUpdate, pos_t'(0),   data_t'(32'haaaa_aaaa));
    send_request(KindDelete, pos_t'(1),   '0);
    send_request(KindDelete, pos_t'(2),   '0);
    send_request(KindRead,   pos_t'(0),   '0);
    send_request(KindRead,   pos_t'(1),   '0);
    send_request(KindRead,   pos_t'(127), '0);
    send_request(KindInsert, pos_t'(127), data_t'(-1));
    send_request(KindSpareLo, pos_t'(127), data_t'(-1));
    send_request(kind_t'(KindSpareLo + 1), pos_t'(64), data_t'(32'h8000_0000));
    send_request(KindSpareHi, pos_t'(0),   data_t'(32'h7fff_ffff));
    send_request(KindClear,  pos_t'(127), data_t'(-1));
    send_request(KindRead,   pos_t'(0),   '0);
    wait_results_drained();

    // response held off while requests keep coming
    hold_requests++;
    repeat (40) begin
      kind_t k;
      k = pick_kind();
      send_request(k, pick_pos(k), pick_value());
    end
    wait_results_drained();

    run_phase(0, 0);
    run_phase(78, 0);
    run_phase(0, 78);
    run_phase(26, 26);
    hold_requests++;
    run_phase(0, 0);

    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("%0d requests sent, %0d results checked, %0d mismatches", items_sent,
             sb.checked, sb.errors);
    $display("covered %0d full-list inserts and %0d out-of-range positions under mixed stalls",
             sb.full_hits, sb.bad_hits);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
